>>> src/sbat_pkg.sv
// ----------------------------------------------------------------------------
// Sprite sort and batch package
// Shared constants, the sort mode codes and the chain control bundle.
// ----------------------------------------------------------------------------
package sbat_pkg;

  localparam int MAX_GLYPHS_DEF   = 64;
  localparam int TEXTURE_BITS_DEF = 16;

  localparam int TEX_W   = 16;
  localparam int DEPTH_W = 16;
  localparam int IDX_W   = 6;
  localparam int BATCH_W = 6;
  localparam int VOFF_W  = 9;
  localparam int MODE_W  = 2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index, taken from the word address
  localparam logic REG_SORT_MODE = 1'b0;

  typedef enum logic [MODE_W-1:0] {
    MODE_TEX_ASC    = 2'd0,
    MODE_DEPTH_ASC  = 2'd1,
    MODE_DEPTH_DESC = 2'd2,
    MODE_KEEP_ORDER = 2'd3
  } sort_mode_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic       ins;
    logic       pop;
    sort_mode_t mode;
  } chain_ctl_t;

endpackage

>>> src/sbat_cell.sv
// ----------------------------------------------------------------------------
// Sprite sort cell
// One slot of the insertion chain: holds one sprite record, compares it
// against the broadcast record and shifts to its neighbors.
// ----------------------------------------------------------------------------
module sbat_cell
  import sbat_pkg::*;
#(
  parameter int TEXTURE_BITS = TEXTURE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  chain_ctl_t              ctl,
  // broadcast record
  input  logic [TEXTURE_BITS-1:0] new_tex,
  input  logic signed [DEPTH_W-1:0] new_depth,
  input  logic [IDX_W-1:0]        new_idx,
  // neighbor toward the head
  input  logic                    prv_ahead,
  input  logic                    prv_valid,
  input  logic [TEXTURE_BITS-1:0] prv_tex,
  input  logic signed [DEPTH_W-1:0] prv_depth,
  input  logic [IDX_W-1:0]        prv_idx,
  // neighbor toward the tail
  input  logic                    nxt_valid,
  input  logic [TEXTURE_BITS-1:0] nxt_tex,
  input  logic signed [DEPTH_W-1:0] nxt_depth,
  input  logic [IDX_W-1:0]        nxt_idx,
  // own contents
  output logic                    ahead,
  output logic                    valid,
  output logic [TEXTURE_BITS-1:0] tex,
  output logic signed [DEPTH_W-1:0] depth,
  output logic [IDX_W-1:0]        idx
);

  logic                      valid_r, valid_nxt;
  logic [TEXTURE_BITS-1:0]   tex_r, tex_nxt;
  logic signed [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic                      goes_first;

  // Strict compare keeps equal keys in arrival order
  always_comb begin
    unique case (ctl.mode)
      MODE_TEX_ASC:    goes_first = new_tex < tex_r;
      MODE_DEPTH_ASC:  goes_first = new_depth < depth_r;
      MODE_DEPTH_DESC: goes_first = new_depth > depth_r;
      MODE_KEEP_ORDER: goes_first = 1'b0;
      default:         goes_first = 1'b0;
    endcase
  end

  // An empty slot always lets the incoming record go ahead of it
  assign ahead = !valid_r || goes_first;

  // Insert shifts the tail down; pop shifts everything toward the head
  always_comb begin
    valid_nxt = valid_r;
    tex_nxt   = tex_r;
    depth_nxt = depth_r;
    idx_nxt   = idx_r;
    if (ctl.pop) begin
      valid_nxt = nxt_valid;
      tex_nxt   = nxt_tex;
      depth_nxt = nxt_depth;
      idx_nxt   = nxt_idx;
    end else if (ctl.ins && ahead) begin
      if (prv_ahead) begin
        valid_nxt = prv_valid;
        tex_nxt   = prv_tex;
        depth_nxt = prv_depth;
        idx_nxt   = prv_idx;
      end else begin
        valid_nxt = 1'b1;
        tex_nxt   = new_tex;
        depth_nxt = new_depth;
        idx_nxt   = new_idx;
      end
    end
  end

  // Hold the slot; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    tex_r   <= tex_nxt;
    depth_r <= depth_nxt;
    idx_r   <= idx_nxt;
  end

  assign valid = valid_r;
  assign tex   = tex_r;
  assign depth = depth_r;
  assign idx   = idx_r;

endmodule

>>> src/sprite_sort_and_batch_core.sv
// ----------------------------------------------------------------------------
// Sprite sort and batch core
// Collects sprite records into a sorted insertion chain, then drains the
// chain in order and tags texture batches and vertex offsets.
// ----------------------------------------------------------------------------
// Throughput: one record per cycle while collecting; each record is placed in
//   its sorted slot of the cell chain in the cycle it is accepted.
// Output: the first result is valid the cycle after the last record; then one
//   result per cycle while out_ready is high; input is held off until the
//   final result of the frame is taken.
// Reset: chain empty, counters and overflow cleared, sort_mode 0.
module sprite_sort_and_batch_core
  import sbat_pkg::*;
#(
  parameter int MAX_GLYPHS   = MAX_GLYPHS_DEF,
  parameter int TEXTURE_BITS = TEXTURE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [TEX_W-1:0]        in_texture_id,
  input  logic signed [DEPTH_W-1:0] in_depth,
  input  logic                    in_last,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [IDX_W-1:0]        out_glyph_index,
  output logic [TEX_W-1:0]        out_tex_out,
  output logic                    out_batch_start,
  output logic [BATCH_W-1:0]      out_batch_number,
  output logic [VOFF_W-1:0]       out_vertex_offset,
  output logic                    out_overflow,
  output logic                    out_end_of_run,
  // configuration port
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [CFG_DATA_W-1:0]   cfg_prdata,
  output logic                    cfg_pready
);

  localparam int CNT_W = $clog2(MAX_GLYPHS + 1);

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } state_t;

  state_t               state_r;
  sort_mode_t           mode_r;
  logic [CNT_W-1:0]     count_r;
  logic                 drop_r;
  logic                 first_r;
  logic [TEXTURE_BITS-1:0] prev_tex_r;
  logic [BATCH_W-1:0]   batch_r;
  logic [IDX_W-1:0]     pos_r;

  logic                 in_acc, out_acc, full, cfg_wr;
  logic                 tex_change;
  logic [31:0]          count_ext, tex_in_ext, tex_head_ext;
  logic [TEXTURE_BITS-1:0] new_tex;
  logic [IDX_W-1:0]     new_idx;
  chain_ctl_t           ctl;

  logic                    c_ahead  [MAX_GLYPHS];
  logic                    c_valid  [MAX_GLYPHS];
  logic [TEXTURE_BITS-1:0] c_tex    [MAX_GLYPHS];
  logic signed [DEPTH_W-1:0] c_depth [MAX_GLYPHS];
  logic [IDX_W-1:0]        c_idx    [MAX_GLYPHS];

  // Configuration port: one register, zero-wait
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_SORT_MODE) ?
                      CFG_DATA_W'(mode_r) : '0;

  // Handshakes
  assign in_ready  = (state_r == ST_COLLECT);
  assign out_valid = (state_r == ST_EMIT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign full      = (count_r == CNT_W'(MAX_GLYPHS));

  // Size the incoming record for the chain
  assign count_ext  = 32'(count_r);
  assign new_idx    = count_ext[IDX_W-1:0];
  assign tex_in_ext = 32'(in_texture_id);
  assign new_tex    = tex_in_ext[TEXTURE_BITS-1:0];

  assign ctl.ins  = in_acc && !full;
  assign ctl.pop  = out_acc;
  assign ctl.mode = mode_r;

  // Build the cell chain
  for (genvar g = 0; g < MAX_GLYPHS; g++) begin : g_cell
    logic                      p_ahead, p_valid, n_valid;
    logic [TEXTURE_BITS-1:0]   p_tex, n_tex;
    logic signed [DEPTH_W-1:0] p_depth, n_depth;
    logic [IDX_W-1:0]          p_idx, n_idx;

    if (g == 0) begin : g_head
      assign p_ahead  = 1'b0;
      assign p_valid  = 1'b0;
      assign p_tex    = '0;
      assign p_depth  = '0;
      assign p_idx    = '0;
    end else begin : g_mid
      assign p_ahead  = c_ahead[g-1];
      assign p_valid  = c_valid[g-1];
      assign p_tex    = c_tex[g-1];
      assign p_depth  = c_depth[g-1];
      assign p_idx    = c_idx[g-1];
    end

    if (g == MAX_GLYPHS - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_tex   = '0;
      assign n_depth = '0;
      assign n_idx   = '0;
    end else begin : g_body
      assign n_valid = c_valid[g+1];
      assign n_tex   = c_tex[g+1];
      assign n_depth = c_depth[g+1];
      assign n_idx   = c_idx[g+1];
    end

    sbat_cell #(
      .TEXTURE_BITS (TEXTURE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_tex    (new_tex),
      .new_depth  (in_depth),
      .new_idx    (new_idx),
      .prv_ahead  (p_ahead),
      .prv_valid  (p_valid),
      .prv_tex    (p_tex),
      .prv_depth  (p_depth),
      .prv_idx    (p_idx),
      .nxt_valid  (n_valid),
      .nxt_tex    (n_tex),
      .nxt_depth  (n_depth),
      .nxt_idx    (n_idx),
      .ahead      (c_ahead[g]),
      .valid      (c_valid[g]),
      .tex        (c_tex[g]),
      .depth      (c_depth[g]),
      .idx        (c_idx[g])
    );
  end

  // Result fields from the head cell and the batch tracking registers
  assign tex_change        = (c_tex[0] != prev_tex_r);
  assign tex_head_ext      = 32'(c_tex[0]);
  assign out_glyph_index   = c_idx[0];
  assign out_tex_out       = tex_head_ext[TEX_W-1:0];
  assign out_batch_start   = first_r || tex_change;
  assign out_batch_number  = (first_r || !tex_change) ? batch_r : batch_r + BATCH_W'(1);
  assign out_vertex_offset = {1'b0, pos_r, 2'b00} + {2'b00, pos_r, 1'b0};
  assign out_overflow      = drop_r;
  assign out_end_of_run    = !c_valid[1];

  // Sequence collect and drain, track batches
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      mode_r  <= MODE_TEX_ASC;
      count_r <= '0;
      drop_r  <= 1'b0;
      first_r <= 1'b1;
      batch_r <= '0;
      pos_r   <= '0;
    end else begin
      if (cfg_wr && cfg_paddr[2] == REG_SORT_MODE) begin
        mode_r <= sort_mode_t'(cfg_pwdata[MODE_W-1:0]);
      end
      unique case (state_r)
        ST_COLLECT: begin
          if (in_acc) begin
            if (full) begin
              drop_r <= 1'b1;
            end else begin
              count_r <= count_r + CNT_W'(1);
            end
            if (in_last) begin
              state_r <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            first_r <= 1'b0;
            batch_r <= out_batch_number;
            pos_r   <= pos_r + IDX_W'(1);
            if (out_end_of_run) begin
              state_r <= ST_COLLECT;
              count_r <= '0;
              drop_r  <= 1'b0;
              first_r <= 1'b1;
              batch_r <= '0;
              pos_r   <= '0;
            end
          end
        end
        default: state_r <= ST_COLLECT;
      endcase
    end
    if (out_acc) begin
      prev_tex_r <= c_tex[0];
    end
  end

endmodule

>>> tb/sv/sprite_sort_and_batch_core_tb.sv
// ----------------------------------------------------------------------------
// Sprite sort and batch core testbench
// Streams sprite frames through the core under each sort mode, predicts the
// sorted, batch-tagged results of every frame and checks each result
// transaction field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module sprite_sort_and_batch_core_tb;
  import sbat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = MAX_GLYPHS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS = 20;
  localparam int REPORT_MAX = 10;
  localparam logic [CFG_ADDR_W-1:0] SORT_MODE_ADDR = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

  typedef struct {
    logic [TEX_W-1:0]          tex;
    logic signed [DEPTH_W-1:0] depth;
    logic                      last;
  } sprite_rec_t;

  typedef struct packed {
    logic [IDX_W-1:0]   glyph_index;
    logic [TEX_W-1:0]   tex;
    logic               batch_start;
    logic [BATCH_W-1:0] batch_number;
    logic [VOFF_W-1:0]  vertex_offset;
    logic               overflow;
    logic               end_of_run;
  } sprite_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [TEX_W-1:0]          in_texture_id = '0;
  logic signed [DEPTH_W-1:0] in_depth = '0;
  logic                      in_last = 1'b0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [IDX_W-1:0]   out_glyph_index;
  logic [TEX_W-1:0]   out_tex_out;
  logic               out_batch_start;
  logic [BATCH_W-1:0] out_batch_number;
  logic [VOFF_W-1:0]  out_vertex_offset;
  logic               out_overflow;
  logic               out_end_of_run;

  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Stimulus and prediction state
  sprite_rec_t    sprite_pending_q[$];
  sprite_result_t sorted_expect_q[$];
  int unsigned    send_idle_pct = 30;
  int unsigned    recv_idle_pct = 45;
  int unsigned    mismatch_count = 0;
  int unsigned    stall_cycles = 0;
  int unsigned    rand_items = 0;

  // Mirror of the core's frame store and sort mode
  sort_mode_t                mode_mirror = MODE_TEX_ASC;
  logic [TEX_W-1:0]          frame_tex[STORE_DEPTH];
  logic signed [DEPTH_W-1:0] frame_depth[STORE_DEPTH];
  int unsigned               frame_count = 0;
  logic                      frame_dropped = 1'b0;

  sprite_sort_and_batch_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_texture_id     (in_texture_id),
    .in_depth          (in_depth),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_glyph_index   (out_glyph_index),
    .out_tex_out       (out_tex_out),
    .out_batch_start   (out_batch_start),
    .out_batch_number  (out_batch_number),
    .out_vertex_offset (out_vertex_offset),
    .out_overflow      (out_overflow),
    .out_end_of_run    (out_end_of_run),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // True when stored entry a must precede entry b under the current mode
  function automatic bit sorts_before(int a, int b);
    case (mode_mirror)
      MODE_TEX_ASC:    return frame_tex[a] < frame_tex[b];
      MODE_DEPTH_ASC:  return frame_depth[a] < frame_depth[b];
      MODE_DEPTH_DESC: return frame_depth[a] > frame_depth[b];
      default:         return 1'b0;
    endcase
  endfunction

  // Store one accepted sprite; on the frame's last one, sort and emit
  task automatic sort_and_batch_predict(input logic [TEX_W-1:0] tex,
                                        input logic signed [DEPTH_W-1:0] depth,
                                        input logic last);
    int order[STORE_DEPTH];
    int cur;
    int j;
    int batch;
    sprite_result_t res;
    if (frame_count < STORE_DEPTH) begin
      frame_tex[frame_count] = tex;
      frame_depth[frame_count] = depth;
      frame_count++;
    end else begin
      frame_dropped = 1'b1;
    end
    if (last) begin
      // Stable insertion sort of entry numbers
      for (int i = 0; i < frame_count; i++) begin
        cur = i;
        j = i;
        while (j > 0 && sorts_before(cur, order[j-1])) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = cur;
      end
      batch = 0;
      for (int i = 0; i < frame_count; i++) begin
        res.batch_start = (i == 0);
        if (i > 0 && frame_tex[order[i]] != frame_tex[order[i-1]]) begin
          res.batch_start = 1'b1;
          batch++;
        end
        res.glyph_index = IDX_W'(order[i]);
        res.tex = frame_tex[order[i]];
        res.batch_number = BATCH_W'(batch);
        res.vertex_offset = VOFF_W'(6 * i);
        res.overflow = frame_dropped;
        res.end_of_run = (i + 1 == frame_count);
        sorted_expect_q.insert(sorted_expect_q.size(), res);
      end
      frame_count = 0;
      frame_dropped = 1'b0;
    end
  endtask

  // Driver: present the next pending sprite, idling at random
  always @(posedge clk) begin
    sprite_rec_t rec;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (sprite_pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        rec = sprite_pending_q.pop_front();
        in_valid <= 1'b1;
        in_texture_id <= rec.tex;
        in_depth <= rec.depth;
        in_last <= rec.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict on every accepted input transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sort_and_batch_predict(in_texture_id, in_depth, in_last);
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    sprite_result_t got;
    sprite_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got.glyph_index = out_glyph_index;
      got.tex = out_tex_out;
      got.batch_start = out_batch_start;
      got.batch_number = out_batch_number;
      got.vertex_offset = out_vertex_offset;
      got.overflow = out_overflow;
      got.end_of_run = out_end_of_run;
      if (sorted_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result: idx=%0d tex=%h start=%b batch=%0d voff=%0d ovf=%b eor=%b",
                   got.glyph_index, got.tex, got.batch_start, got.batch_number,
                   got.vertex_offset, got.overflow, got.end_of_run);
      end else begin
        want = sorted_expect_q.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch exp: idx=%0d tex=%h start=%b batch=%0d voff=%0d ovf=%b eor=%b",
                     want.glyph_index, want.tex, want.batch_start, want.batch_number,
                     want.vertex_offset, want.overflow, want.end_of_run);
            $display("         got: idx=%0d tex=%h start=%b batch=%0d voff=%0d ovf=%b eor=%b",
                     got.glyph_index, got.tex, got.batch_start, got.batch_number,
                     got.vertex_offset, got.overflow, got.end_of_run);
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_sprite(input logic [TEX_W-1:0] tex,
                             input logic signed [DEPTH_W-1:0] depth,
                             input logic last);
    sprite_rec_t rec;
    rec.tex = tex;
    rec.depth = depth;
    rec.last = last;
    sprite_pending_q.insert(sprite_pending_q.size(), rec);
  endtask

  // Queue one frame of n sprites; keys come from a small pool or full range
  task automatic add_frame(input int n);
    logic [TEX_W-1:0]          tex_pool[3];
    logic signed [DEPTH_W-1:0] dep_pool[3];
    bit narrow_tex;
    bit narrow_dep;
    logic [TEX_W-1:0] tex;
    logic signed [DEPTH_W-1:0] depth;
    narrow_tex = ($urandom_range(9) < 6);
    narrow_dep = ($urandom_range(9) < 5);
    for (int k = 0; k < 3; k++) begin
      tex_pool[k] = TEX_W'($urandom);
      case ($urandom_range(3))
        0: dep_pool[k] = 16'sh8000;
        1: dep_pool[k] = 16'sh7fff;
        default: dep_pool[k] = DEPTH_W'($urandom);
      endcase
    end
    for (int i = 0; i < n; i++) begin
      tex = narrow_tex ? tex_pool[$urandom_range(2)] : 16'($urandom);
      depth = narrow_dep ? dep_pool[$urandom_range(2)] : 16'($urandom);
      push_sprite(tex, depth, i == n - 1);
    end
    rand_items += n;
  endtask

  // Wait until every queued sprite is in and every result is out
  task automatic wait_drained();
    do @(negedge clk);
    while (sprite_pending_q.size() > 0 || in_valid || sorted_expect_q.size() > 0);
    repeat (4) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr[2] == REG_SORT_MODE)
      mode_mirror = sort_mode_t'(data[MODE_W-1:0]);
  endtask

  initial begin
    int phase;
    int unsigned phase_start;
    bit big_done;
    big_done = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Single sprite frame at the key extremes, reset mode
    push_sprite(16'hffff, 16'sh8000, 1'b1);
    // Texture ties and extremes
    push_sprite(16'd5, 16'sh7fff, 1'b0);
    push_sprite(16'd3, 16'sh8000, 1'b0);
    push_sprite(16'd5, 16'sh0000, 1'b0);
    push_sprite(16'd3, -16'sd1, 1'b0);
    push_sprite(16'h0000, 16'sh0100, 1'b0);
    push_sprite(16'hffff, 16'sh7fff, 1'b1);
    wait_drained();

    // Depth ascending and descending over the same frame with ties
    for (int m = 0; m < 2; m++) begin
      cfg_write(SORT_MODE_ADDR, (m == 0) ? 32'(MODE_DEPTH_ASC) : 32'(MODE_DEPTH_DESC));
      push_sprite(16'd7, 16'sh7fff, 1'b0);
      push_sprite(16'd8, 16'sh8000, 1'b0);
      push_sprite(16'd7, 16'sh0000, 1'b0);
      push_sprite(16'd9, -16'sd1, 1'b0);
      push_sprite(16'd9, 16'sh0000, 1'b1);
      wait_drained();
    end

    // Keep-order mode, written with the upper data bits set, keeps arrival order
    cfg_write(SORT_MODE_ADDR, 32'hffff_fffc | 32'(MODE_KEEP_ORDER));
    push_sprite(16'd40, 16'sh0010, 1'b0);
    push_sprite(16'd10, 16'sh8000, 1'b0);
    push_sprite(16'd40, 16'sh7fff, 1'b0);
    push_sprite(16'd20, 16'sh0000, 1'b1);
    wait_drained();

    // Write to an unmapped register leaves the mode alone
    cfg_write(UNMAPPED_ADDR, 32'(MODE_TEX_ASC));
    push_sprite(16'd2, 16'sh0001, 1'b0);
    push_sprite(16'd1, 16'sh0002, 1'b0);
    push_sprite(16'd2, 16'sh0003, 1'b1);
    wait_drained();

    // Random frames in three idling phases
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_start = rand_items;
      while (rand_items - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(4) == 0)
          cfg_write(UNMAPPED_ADDR, $urandom);
        cfg_write(SORT_MODE_ADDR, $urandom);
        for (int f = $urandom_range(2, 4); f > 0; f--) begin
          if (phase == 1 && !big_done) begin
            // Overfill the store; the last sprite is one of the dropped ones
            add_frame(STORE_DEPTH + 1 + $urandom_range(2));
            big_done = 1'b1;
          end else begin
            add_frame($urandom_range(1, 8));
          end
        end
        wait_drained();
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && sorted_expect_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
